FILE: sv/windowed_sample_integrator_with_error_unit_macros.svh
// Assertion macros shared by the integrator RTL.
`ifndef WINDOWED_SAMPLE_INTEGRATOR_WITH_ERROR_UNIT_MACROS_SVH
`define WINDOWED_SAMPLE_INTEGRATOR_WITH_ERROR_UNIT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define WSI_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property at every clock edge, reset included.
`define WSI_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/wsi_pkg.sv
// Shared constants and types of the windowed sample integrator.
`timescale 1ns / 1ps
package wsi_pkg;

  localparam int COUNT_BITS = 16;

  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  localparam int SQ_IN_W = 64;
  localparam int SQ_OUT_W = SQ_IN_W / 2;
  localparam int SQ_REM_W = SQ_OUT_W + 3;
  localparam int SQ_CNT_W = $clog2(SQ_OUT_W + 1);

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_UPDATE,
    ST_LASTCHK,
    ST_WEIGHT,
    ST_START,
    ST_MUL1,
    ST_MUL2,
    ST_SQRT,
    ST_OUT,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    REG_OFFSET    = 3'd0,
    REG_START_LIM = 3'd1,
    REG_START_EN  = 3'd2,
    REG_STOP_LIM  = 3'd3,
    REG_STOP_EN   = 3'd4,
    REG_PT_LIMIT  = 3'd5,
    REG_USE_SIGMA = 3'd6
  } reg_idx_t;

endpackage

FILE: sv/wsi_sermul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module wsi_sermul import wsi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_A_W-1:0] mcand,
  input  logic [MUL_B_W-1:0] mplier,
  output logic [MUL_P_W-1:0] prod,
  output unit_status_t       status
);

  logic [MUL_P_W-1:0]   acc_r, acc_nxt;
  logic [MUL_P_W-1:0]   sh_r, sh_nxt;
  logic [MUL_B_W-1:0]   mp_r, mp_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    mp_nxt   = mp_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      sh_nxt   = MUL_P_W'(mcand);
      mp_nxt   = mplier;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_nxt = acc_r + sh_r;
      end
      sh_nxt  = sh_r << 1;
      mp_nxt  = mp_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(MUL_B_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    mp_r  <= mp_nxt;
  end

  assign prod = acc_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

FILE: sv/wsi_isqrt.sv
// Restoring integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module wsi_isqrt import wsi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SQ_IN_W-1:0]  value,
  output logic [SQ_OUT_W-1:0] root,
  output unit_status_t        status
);

  logic [SQ_IN_W-1:0]  val_r, val_nxt;
  logic [SQ_REM_W-1:0] rem_r, rem_nxt;
  logic [SQ_OUT_W-1:0] root_r, root_nxt;
  logic [SQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [SQ_REM_W-1:0] rem_sh;
  logic [SQ_REM_W-1:0] trial;

  always_comb begin
    rem_sh   = {rem_r[SQ_REM_W-3:0], val_r[SQ_IN_W-1 -: 2]};
    trial    = SQ_REM_W'({root_r, 2'b01});
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      val_nxt  = value;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = val_r << 2;
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[SQ_OUT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == SQ_CNT_W'(SQ_OUT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

FILE: sv/windowed_sample_integrator_with_error_unit.sv
// Top level of the windowed sample integrator with error propagation.
// The input channel takes one point (x, y, sigma, end-of-data mark) per
// transaction; the output channel returns zero, one or two results per point,
// each carrying the reported point, its trapezoidal weight, the running
// integral and the running error. Points outside the enabled window, and all
// points after the point limit until end of data, are never reported; an
// outside point with the end-of-data mark still closes the held point.
// Each result takes 32-step bit-serial multiplications, two in sequence and
// a third alongside the first, and then a 32-step square root.
// One point is processed at a time; in_ready is high only when the block is
// idle, but a finished result waits in the output register, so the next
// point may be accepted while the receiver stalls. A stalled receiver holds
// up processing only when a further result is ready to be loaded.
// The configuration registers sit on an APB-style port at byte addresses 8*i
// and must be written only while the block is idle, which is not enforced.
// Synchronous reset restores control and configuration and clears out_valid.
`timescale 1ns / 1ps
module windowed_sample_integrator_with_error_unit import wsi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_sample_x,
  input  logic [31:0] in_sample_y,
  input  logic [30:0] in_sample_sigma,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_point_x,
  output logic [31:0] out_point_y,
  output logic [30:0] out_point_sigma,
  output logic [47:0] out_running_integral,
  output logic [31:0] out_running_error,
  output logic [32:0] out_weight,
  output logic        out_negative_variance,
  output logic        out_last_point,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  `include "windowed_sample_integrator_with_error_unit_macros.svh"

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Configuration registers.
  logic [47:0] offset_r;
  logic [31:0] start_lim_r, stop_lim_r;
  logic        start_en_r, stop_en_r, use_sig_r;
  logic [15:0] plim_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      start_lim_r <= '0;
      start_en_r  <= 1'b0;
      stop_lim_r  <= '0;
      stop_en_r   <= 1'b0;
      plim_r      <= '0;
      use_sig_r   <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_OFFSET:    offset_r    <= pwdata[47:0];
        REG_START_LIM: start_lim_r <= pwdata[31:0];
        REG_START_EN:  start_en_r  <= pwdata[0];
        REG_STOP_LIM:  stop_lim_r  <= pwdata[31:0];
        REG_STOP_EN:   stop_en_r   <= pwdata[0];
        REG_PT_LIMIT:  plim_r      <= pwdata[15:0];
        REG_USE_SIGMA: use_sig_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_OFFSET:    prdata = 64'(offset_r);
      REG_START_LIM: prdata = 64'(start_lim_r);
      REG_START_EN:  prdata = 64'(start_en_r);
      REG_STOP_LIM:  prdata = 64'(stop_lim_r);
      REG_STOP_EN:   prdata = 64'(stop_en_r);
      REG_PT_LIMIT:  prdata = 64'(plim_r);
      REG_USE_SIGMA: prdata = 64'(use_sig_r);
      default:       prdata = '0;
    endcase
  end

  // Datapath and control state.
  state_t              state_r, state_nxt;
  logic [31:0]         ix_r, ix_nxt, iy_r, iy_nxt;
  logic [30:0]         is_r, is_nxt;
  logic                ieod_r, ieod_nxt;
  logic [31:0]         before_x_r, before_x_nxt, held_x_r, held_x_nxt;
  logic [31:0]         held_y_r, held_y_nxt;
  logic [30:0]         held_s_r, held_s_nxt;
  logic                held_valid_r, held_valid_nxt, held_first_r, held_first_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt, count_inc;
  logic [47:0]         integ_r, integ_nxt;
  logic [63:0]         var_r, var_nxt;
  logic                limit_r, limit_nxt, close_r, close_nxt;
  logic [31:0]         ex_r, ex_nxt, ey_r, ey_nxt;
  logic [30:0]         es_r, es_nxt;
  logic [35:0]         w2_r, w2_nxt;
  logic [32:0]         w_r, w_nxt;
  logic                last_r, last_nxt, neg_r, neg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         o_x_r, o_x_nxt, o_y_r, o_y_nxt, o_err_r, o_err_nxt;
  logic [30:0]         o_s_r, o_s_nxt;
  logic [47:0]         o_int_r, o_int_nxt;
  logic [32:0]         o_w_r, o_w_nxt;
  logic                o_neg_r, o_neg_nxt, o_last_r, o_last_nxt;

  logic                ok;
  logic signed [35:0]  sx_ix, sx_hx, sx_bx, sx_start, sx_stop, ext_start, ext_stop;
  logic signed [35:0]  w2_first, w2_last;
  logic [34:0]         w_half;
  logic [32:0]         aw;
  logic [31:0]         ay;
  logic [48:0]         p_mag;
  logic signed [50:0]  p_sgn, int_sum;
  logic [78:0]         term_raw;
  logic [62:0]         term;
  logic signed [64:0]  var_sum;
  logic [63:0]         var_new;

  logic                mul_a_start, mul_b_start, sq_start;
  logic [MUL_A_W-1:0]  mcand_b;
  logic [MUL_P_W-1:0]  prod_a, prod_b;
  logic [SQ_IN_W-1:0]  sq_val;
  logic [SQ_OUT_W-1:0] sq_root;
  unit_status_t        mul_a_st, mul_b_st, sq_st;

  assign ok = !limit_r
      && !(start_en_r && ($signed(ix_r) < $signed(start_lim_r)))
      && !(stop_en_r && ($signed(ix_r) > $signed(stop_lim_r)));

  assign sx_ix     = 36'($signed(ix_r));
  assign sx_hx     = 36'($signed(held_x_r));
  assign sx_bx     = 36'($signed(before_x_r));
  assign sx_start  = 36'($signed(start_lim_r));
  assign sx_stop   = 36'($signed(stop_lim_r));
  assign ext_start = start_en_r ? ((sx_hx - sx_start) <<< 1) : '0;
  assign ext_stop  = stop_en_r ? ((sx_stop - sx_hx) <<< 1) : '0;
  assign w2_first  = held_first_r ? (sx_ix - sx_hx + ext_start) : (sx_ix - sx_bx);
  assign w2_last   = (held_first_r ? ext_start : (sx_hx - sx_bx)) + ext_stop;

  assign w_half    = w2_r[35:1];
  assign aw        = w_r[32] ? (~w_r + 33'd1) : w_r;
  assign ay        = ey_r[31] ? (~ey_r + 32'd1) : ey_r;
  assign count_inc = (count_r != CNT_MAX) ? (count_r + 1'b1) : count_r;

  assign p_mag     = prod_a[64:16];
  assign p_sgn     = (w_r[32] ^ ey_r[31]) ? -$signed(51'(p_mag)) : $signed(51'(p_mag));
  assign int_sum   = 51'($signed(integ_r)) + p_sgn;

  assign term_raw  = prod_b[94:16];
  assign term      = (term_raw[78:63] != '0) ? '1 : term_raw[62:0];
  assign var_sum   = w_r[32] ? (65'($signed(var_r)) - $signed(65'(term)))
                             : (65'($signed(var_r)) + $signed(65'(term)));
  assign var_new   = (var_sum[64] != var_sum[63])
                     ? {var_sum[64], {63{~var_sum[64]}}} : var_sum[63:0];

  assign mcand_b   = (state_r == ST_MUL1) ? prod_b[MUL_A_W-1:0] : MUL_A_W'(aw);

  always_comb begin
    state_nxt      = state_r;
    ix_nxt         = ix_r;
    iy_nxt         = iy_r;
    is_nxt         = is_r;
    ieod_nxt       = ieod_r;
    before_x_nxt   = before_x_r;
    held_x_nxt     = held_x_r;
    held_y_nxt     = held_y_r;
    held_s_nxt     = held_s_r;
    held_valid_nxt = held_valid_r;
    held_first_nxt = held_first_r;
    count_nxt      = count_r;
    integ_nxt      = integ_r;
    var_nxt        = var_r;
    limit_nxt      = limit_r;
    close_nxt      = close_r;
    ex_nxt         = ex_r;
    ey_nxt         = ey_r;
    es_nxt         = es_r;
    w2_nxt         = w2_r;
    w_nxt          = w_r;
    last_nxt       = last_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    o_x_nxt        = o_x_r;
    o_y_nxt        = o_y_r;
    o_s_nxt        = o_s_r;
    o_int_nxt      = o_int_r;
    o_err_nxt      = o_err_r;
    o_w_nxt        = o_w_r;
    o_neg_nxt      = o_neg_r;
    o_last_nxt     = o_last_r;
    mul_a_start    = 1'b0;
    mul_b_start    = 1'b0;
    sq_start       = 1'b0;
    sq_val         = var_new[63] ? '0 : var_new;
    in_ready       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ix_nxt    = in_sample_x;
          iy_nxt    = in_sample_y;
          is_nxt    = use_sig_r ? in_sample_sigma : '0;
          ieod_nxt  = in_end_of_data;
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (ok && held_valid_r) begin
          w2_nxt    = w2_first;
          last_nxt  = 1'b0;
          ex_nxt    = held_x_r;
          ey_nxt    = held_y_r;
          es_nxt    = held_s_r;
          state_nxt = ST_WEIGHT;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        close_nxt = 1'b0;
        if (ok) begin
          before_x_nxt   = held_valid_r ? held_x_r : '0;
          held_first_nxt = !held_valid_r;
          held_x_nxt     = ix_r;
          held_y_nxt     = iy_r;
          held_s_nxt     = is_r;
          held_valid_nxt = 1'b1;
          count_nxt      = count_inc;
          close_nxt      = (plim_r != '0) && (32'(count_inc) == 32'(plim_r));
        end
        state_nxt = ST_LASTCHK;
      end
      ST_LASTCHK: begin
        if ((close_r || ieod_r) && held_valid_r) begin
          w2_nxt         = w2_last;
          last_nxt       = 1'b1;
          ex_nxt         = held_x_r;
          ey_nxt         = held_y_r;
          es_nxt         = held_s_r;
          held_valid_nxt = 1'b0;
          state_nxt      = ST_WEIGHT;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_WEIGHT: begin
        if (w_half[34:32] == 3'b000 || w_half[34:32] == 3'b111) begin
          w_nxt = w_half[32:0];
        end else begin
          w_nxt = w_half[34] ? {1'b1, 32'd0} : {1'b0, 32'hFFFF_FFFF};
        end
        state_nxt = ST_START;
      end
      ST_START: begin
        mul_a_start = 1'b1;
        mul_b_start = 1'b1;
        state_nxt   = ST_MUL1;
      end
      ST_MUL1: begin
        if (mul_a_st.done) begin
          if (int_sum[50:47] == 4'b0000 || int_sum[50:47] == 4'b1111) begin
            integ_nxt = int_sum[47:0];
          end else begin
            integ_nxt = {int_sum[50], {47{~int_sum[50]}}};
          end
          mul_b_start = 1'b1;
          state_nxt   = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (mul_b_st.done) begin
          var_nxt   = var_new;
          neg_nxt   = var_new[63];
          sq_start  = 1'b1;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_st.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_x_nxt       = ex_r;
          o_y_nxt       = ey_r;
          o_s_nxt       = es_r;
          o_int_nxt     = integ_r;
          o_err_nxt     = sq_root;
          o_w_nxt       = w_r;
          o_neg_nxt     = neg_r;
          o_last_nxt    = last_r;
          state_nxt     = last_r ? ST_FINISH : ST_UPDATE;
        end
      end
      ST_FINISH: begin
        if (close_r) begin
          limit_nxt = 1'b1;
        end
        if (ieod_r) begin
          before_x_nxt   = '0;
          held_x_nxt     = '0;
          held_y_nxt     = '0;
          held_s_nxt     = '0;
          held_valid_nxt = 1'b0;
          held_first_nxt = 1'b1;
          count_nxt      = '0;
          integ_nxt      = offset_r;
          var_nxt        = '0;
          limit_nxt      = 1'b0;
        end
        close_nxt = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      before_x_r   <= '0;
      held_x_r     <= '0;
      held_y_r     <= '0;
      held_s_r     <= '0;
      held_valid_r <= 1'b0;
      held_first_r <= 1'b1;
      count_r      <= '0;
      integ_r      <= '0;
      var_r        <= '0;
      limit_r      <= 1'b0;
      close_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      before_x_r   <= before_x_nxt;
      held_x_r     <= held_x_nxt;
      held_y_r     <= held_y_nxt;
      held_s_r     <= held_s_nxt;
      held_valid_r <= held_valid_nxt;
      held_first_r <= held_first_nxt;
      count_r      <= count_nxt;
      integ_r      <= integ_nxt;
      var_r        <= var_nxt;
      limit_r      <= limit_nxt;
      close_r      <= close_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ix_r     <= ix_nxt;
    iy_r     <= iy_nxt;
    is_r     <= is_nxt;
    ieod_r   <= ieod_nxt;
    ex_r     <= ex_nxt;
    ey_r     <= ey_nxt;
    es_r     <= es_nxt;
    w2_r     <= w2_nxt;
    w_r      <= w_nxt;
    last_r   <= last_nxt;
    neg_r    <= neg_nxt;
    o_x_r    <= o_x_nxt;
    o_y_r    <= o_y_nxt;
    o_s_r    <= o_s_nxt;
    o_int_r  <= o_int_nxt;
    o_err_r  <= o_err_nxt;
    o_w_r    <= o_w_nxt;
    o_neg_r  <= o_neg_nxt;
    o_last_r <= o_last_nxt;
  end

  wsi_sermul u_mul_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_a_start),
    .mcand  (MUL_A_W'(aw)),
    .mplier (ay),
    .prod   (prod_a),
    .status (mul_a_st)
  );

  wsi_sermul u_mul_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_b_start),
    .mcand  (mcand_b),
    .mplier (MUL_B_W'(es_r)),
    .prod   (prod_b),
    .status (mul_b_st)
  );

  wsi_isqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .value  (sq_val),
    .root   (sq_root),
    .status (sq_st)
  );

  assign out_valid             = out_valid_r;
  assign out_point_x           = o_x_r;
  assign out_point_y           = o_y_r;
  assign out_point_sigma       = o_s_r;
  assign out_running_integral  = o_int_r;
  assign out_running_error     = o_err_r;
  assign out_weight            = o_w_r;
  assign out_negative_variance = o_neg_r;
  assign out_last_point        = o_last_r;

  `WSI_CHECK(a_mul_pair, (state_r == ST_MUL1 && mul_a_st.done) |-> mul_b_st.done, "multipliers out of step")
  `WSI_CHECK(a_out_load, $rose(out_valid_r) |-> $past(state_r == ST_OUT), "result loaded outside output state")
  `WSI_CHECK(a_eod_clear, (state_r == ST_FINISH && ieod_r) |=> !held_valid_r, "held point survives end of data")
  `WSI_CHECK_ALWAYS(a_reset, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "reset not applied")

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the windowed sample integrator with error propagation.
`timescale 1ns / 1ps
module tb;
  import wsi_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] sigma;
    logic [47:0] integral;
    logic [31:0] error;
    logic [32:0] weight;
    logic        neg_var;
    logic        last;
  } point_result_t;

  class integrator_scoreboard;
    localparam longint I48_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint I48_MIN = -I48_MAX - 1;
    localparam longint WEIGHT_MAX = 64'sh0_FFFF_FFFF;
    localparam longint WEIGHT_MIN = -WEIGHT_MAX - 1;
    localparam logic signed [127:0] VAR_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] VAR_MIN = -VAR_MAX - 1;

    longint offset, start_lim, stop_lim;
    bit start_en, stop_en, use_sig;
    int unsigned point_lim;

    longint prev_x, held_x, held_y, integ, var_sum;
    longint unsigned held_s;
    bit held_valid, held_first, limit_hit;
    int unsigned count;

    point_result_t pending_results[$];

    function new();
      offset = 0;
      start_lim = 0;
      stop_lim = 0;
      start_en = 0;
      stop_en = 0;
      point_lim = 0;
      use_sig = 1;
      restart();
    endfunction

    function void restart();
      prev_x = 0;
      held_x = 0;
      held_y = 0;
      held_s = 0;
      held_valid = 0;
      held_first = 1;
      count = 0;
      integ = offset;
      var_sum = 0;
      limit_hit = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [63:0] v);
      case (idx)
        REG_OFFSET:    offset = $signed(v[47:0]);
        REG_START_LIM: start_lim = $signed(v[31:0]);
        REG_START_EN:  start_en = v[0];
        REG_STOP_LIM:  stop_lim = $signed(v[31:0]);
        REG_STOP_EN:   stop_en = v[0];
        REG_PT_LIMIT:  point_lim = v[15:0];
        REG_USE_SIGMA: use_sig = v[0];
        default: ;
      endcase
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, t;
      logic [127:0] sq;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (64'd1 << i);
        sq = {64'd0, t} * {64'd0, t};
        if (sq <= {64'd0, v}) r = t;
      end
      return r;
    endfunction

    function void emit(longint w2, bit last);
      longint w, p, tv;
      longint unsigned aw, ay;
      logic [127:0] prod;
      logic signed [127:0] acc;
      point_result_t r;
      w = w2 >>> 1;
      if (w > WEIGHT_MAX) w = WEIGHT_MAX;
      if (w < WEIGHT_MIN) w = WEIGHT_MIN;
      aw = (w < 0) ? -w : w;
      ay = (held_y < 0) ? -held_y : held_y;
      prod = ({64'd0, aw} * {64'd0, ay}) >> 16;
      p = prod[63:0];
      if ((w < 0) != (held_y < 0)) p = -p;
      tv = integ + p;
      if (tv > I48_MAX) tv = I48_MAX;
      if (tv < I48_MIN) tv = I48_MIN;
      integ = tv;
      prod = ({64'd0, aw} * {64'd0, held_s} * {64'd0, held_s}) >> 16;
      if (prod > 128'h7FFF_FFFF_FFFF_FFFF) prod = 128'h7FFF_FFFF_FFFF_FFFF;
      acc = var_sum;
      acc = (w >= 0) ? acc + $signed(prod) : acc - $signed(prod);
      if (acc > VAR_MAX) acc = VAR_MAX;
      if (acc < VAR_MIN) acc = VAR_MIN;
      var_sum = acc[63:0];
      r.x = held_x[31:0];
      r.y = held_y[31:0];
      r.sigma = held_s[30:0];
      r.integral = integ[47:0];
      r.error = (var_sum < 0) ? 32'd0 : 32'(root(var_sum));
      r.weight = w[32:0];
      r.neg_var = (var_sum < 0);
      r.last = last;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void note_point(logic [31:0] xi, logic [31:0] yi, logic [30:0] si, logic eod);
      longint x, y, w2;
      bit close, ok;
      x = $signed(xi);
      y = $signed(yi);
      close = 0;
      if (!limit_hit) begin
        ok = !(start_en && x < start_lim) && !(stop_en && x > stop_lim);
        if (ok) begin
          if (held_valid) begin
            if (held_first)
              w2 = (x - held_x) + (start_en ? 2 * (held_x - start_lim) : 0);
            else
              w2 = x - prev_x;
            emit(w2, 1'b0);
          end
          prev_x = held_valid ? held_x : 0;
          held_first = !held_valid;
          held_x = x;
          held_y = y;
          held_s = use_sig ? si : 0;
          held_valid = 1;
          if (count < 65535) count++;
          if (point_lim != 0 && count == point_lim) close = 1;
        end
      end
      if ((close || eod) && held_valid) begin
        w2 = held_first ? (start_en ? 2 * (held_x - start_lim) : 0) : held_x - prev_x;
        w2 += stop_en ? 2 * (stop_lim - held_x) : 0;
        emit(w2, 1'b1);
        held_valid = 0;
      end
      if (close) limit_hit = 1;
      if (eod) restart();
    endfunction

    function void check_point_result(point_result_t got, ref string faults[$]);
      point_result_t e;
      e = pending_results.pop_front();
      if (got.x !== e.x)
        faults = {faults, $sformatf("point_x %h, expected %h", got.x, e.x)};
      if (got.y !== e.y)
        faults = {faults, $sformatf("point_y %h, expected %h", got.y, e.y)};
      if (got.sigma !== e.sigma)
        faults = {faults, $sformatf("point_sigma %h, expected %h", got.sigma, e.sigma)};
      if (got.integral !== e.integral)
        faults = {faults, $sformatf("integral %h, expected %h", got.integral, e.integral)};
      if (got.error !== e.error)
        faults = {faults, $sformatf("error %h, expected %h", got.error, e.error)};
      if (got.weight !== e.weight)
        faults = {faults, $sformatf("weight %h, expected %h", got.weight, e.weight)};
      if (got.neg_var !== e.neg_var)
        faults = {faults,
                  $sformatf("negative_variance %b, expected %b", got.neg_var, e.neg_var)};
      if (got.last !== e.last)
        faults = {faults, $sformatf("last_point %b, expected %b", got.last, e.last)};
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_sample_x;
  logic [31:0] in_sample_y;
  logic [30:0] in_sample_sigma;
  logic        in_end_of_data;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_point_x;
  logic [31:0] out_point_y;
  logic [30:0] out_point_sigma;
  logic [47:0] out_running_integral;
  logic [31:0] out_running_error;
  logic [32:0] out_weight;
  logic        out_negative_variance;
  logic        out_last_point;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  integrator_scoreboard sb;
  int errors;
  int points_sent;
  int results_checked;
  int cycles;
  int stall_left;
  bit quiet;

  windowed_sample_integrator_with_error_unit u_dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report(string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    point_result_t got;
    string faults[$];
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_point(in_sample_x, in_sample_y, in_sample_sigma, in_end_of_data);
        points_sent++;
      end
      if (out_valid && out_ready) begin
        got = '{out_point_x, out_point_y, out_point_sigma, out_running_integral,
                out_running_error, out_weight, out_negative_variance, out_last_point};
        results_checked++;
        if (sb.pending_results.size() == 0) begin
          report($sformatf("result for x=%h arrived with nothing expected", out_point_x));
        end else begin
          faults.delete();
          sb.check_point_result(got, faults);
          foreach (faults[i]) report(faults[i]);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [63:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 6'(idx) << 3;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(logic [47:0] offset, logic [31:0] start_lim, bit start_en,
                           logic [31:0] stop_lim, bit stop_en, logic [15:0] point_lim,
                           bit use_sig);
    write_reg(REG_OFFSET, 64'(offset));
    write_reg(REG_START_LIM, 64'(start_lim));
    write_reg(REG_START_EN, 64'(start_en));
    write_reg(REG_STOP_LIM, 64'(stop_lim));
    write_reg(REG_STOP_EN, 64'(stop_en));
    write_reg(REG_PT_LIMIT, 64'(point_lim));
    write_reg(REG_USE_SIGMA, 64'(use_sig));
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send(logic [31:0] x, logic [31:0] y, logic [30:0] s, logic eod);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_x <= x;
    in_sample_y <= y;
    in_sample_sigma <= s;
    in_end_of_data <= eod;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_y();
    if ($urandom_range(0, 1)) return $urandom();
    return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
  endfunction

  function automatic logic [30:0] rand_sigma();
    if ($urandom_range(0, 1)) return 31'($urandom());
    return 31'($urandom_range(0, 1 << 18));
  endfunction

  task automatic random_sets(int count, bit hold_midway);
    int target, len;
    logic [31:0] x;
    bit paused;
    target = points_sent + count;
    paused = 0;
    while (points_sent < target) begin
      if (hold_midway && !paused && points_sent > target - count / 2) begin
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
        paused = 1;
      end
      if ($urandom_range(0, 99) < 6) begin
        send($urandom(), $urandom(), 31'($urandom()), 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, 6);
        x = 32'($signed($urandom_range(0, 60 << 16)) - (30 << 16));
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) x = $urandom();
          else if ($urandom_range(0, 7) == 0) x = x - $urandom_range(0, 3 << 16);
          else x = x + $urandom_range(0, 5 << 16);
          send(x, rand_y(), rand_sigma(), i == len - 1);
        end
      end
    end
  endtask

  initial begin
    sb = new();
    errors = 0;
    points_sent = 0;
    results_checked = 0;
    cycles = 0;
    quiet = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_x = '0;
    in_sample_y = '0;
    in_sample_sigma = '0;
    in_end_of_data = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    configure(48'h1_0000, -(32'sd10 << 16), 1'b1, 32'sd10 << 16, 1'b1, 16'd3, 1'b1);
    send(32'h0, 32'h1_0000, 31'h1_0000, 1'b1);
    send(-(32'sd10 << 16), 32'h2_0000, 31'h8000, 1'b0);
    send(32'sd10 << 16, 32'hFFFF_0000, 31'h4000, 1'b1);
    send(-(32'sd11 << 16), 32'h5_0000, 31'h1_0000, 1'b1);
    send(32'h1_0000, 32'h1_0000, 31'h1_0000, 1'b0);
    send(32'h2_0000, 32'h2_0000, 31'h1_0000, 1'b0);
    send(32'h3_0000, 32'h3_0000, 31'h1_0000, 1'b0);
    send(32'h4_0000, 32'h4_0000, 31'h1_0000, 1'b0);
    send(32'h5_0000, 32'h5_0000, 31'h1_0000, 1'b1);
    send(32'h0, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    send(32'h1_0000, 32'h8000_0000, 31'h0, 1'b1);
    send(32'h5_0000, 32'h1_0000, 31'h7FFF_FFFF, 1'b0);
    send(32'hFFFB_0000, 32'h1_0000, 31'h7FFF_FFFF, 1'b0);
    send(32'h0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    random_sets(ITEMS_PER_PHASE - 14, 1'b0);
    drain();

    quiet = 1;
    configure(48'h0, 32'h0, 1'b0, 32'h0, 1'b0, 16'd0, 1'b1);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    send(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    random_sets(ITEMS_PER_PHASE - 3, 1'b0);
    drain();
    quiet = 0;

    configure(48'h7FFF_FFFF_FFFF, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1, 16'hFFFF, 1'b0);
    random_sets(ITEMS_PER_PHASE, 1'b1);
    drain();

    configure(48'h8000_0000_0000, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0, 16'd1, 1'b1);
    random_sets(ITEMS_PER_PHASE, 1'b0);
    drain();

    configure(48'($urandom()), -(32'sd1000 << 16), 1'b0, 32'sd50 << 16, 1'b1, 16'd2, 1'b1);
    random_sets(ITEMS_PER_PHASE, 1'b0);
    drain();

    configure({16'($urandom()), 32'($urandom())},
              32'($signed($urandom_range(0, 40 << 16)) - (30 << 16)),
              1'($urandom_range(0, 1)),
              32'($signed($urandom_range(0, 40 << 16)) - (10 << 16)),
              1'($urandom_range(0, 1)),
              16'($urandom_range(0, 8)), 1'($urandom_range(0, 1)));
    random_sets(ITEMS_PER_PHASE, 1'b0);
    drain();

    $display("Sent %0d points over six register settings, checked %0d results.",
             points_sent, results_checked);
    $display("Covered windowed and unwindowed sets, point limits and saturating sums.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/wsi_pkg.sv
sv/wsi_sermul.sv
sv/wsi_isqrt.sv
sv/windowed_sample_integrator_with_error_unit.sv
verif/tb.sv
